/* hw/rtl/gptchk_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the GPT header and entry-array checker:
// verdict codes, header constants, byte-wide CRC-32 step and signature table.
// No dependencies.
package gptchk_pkg;

	localparam int unsigned DEF_MAX_SECTOR_BYTES = 4096;
	localparam int unsigned SECTOR_W             = 13;
	localparam logic [SECTOR_W-1:0] SECTOR_RESET = 13'd512;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [31:0] GPT_REVISION = 32'h0001_0000;
	localparam logic [31:0] MIN_HDR_SIZE = 32'd92;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SIGNATURE = 3'd1,
		ST_REVISION  = 3'd2,
		ST_SIZE      = 3'd3,
		ST_MY_LBA    = 3'd4,
		ST_HDR_CRC   = 3'd5,
		ST_ENTRY_CRC = 3'd6,
		ST_NO_HDR    = 3'd7
	} gpt_status_t;

	// Reflected CRC-32 update by one byte, LSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// "EFI PART", byte by byte.
	function automatic logic [7:0] sig_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h45;
			3'd1: ch = 8'h46;
			3'd2: ch = 8'h49;
			3'd3: ch = 8'h20;
			3'd4: ch = 8'h50;
			3'd5: ch = 8'h41;
			3'd6: ch = 8'h52;
			default: ch = 8'h54;
		endcase
		return ch;
	endfunction

endpackage

/* hw/rtl/gpt_header_crc_checker_unit.sv */
`timescale 1ns / 1ps
// GPT header and partition-entry-array checker with streaming CRC-32.
// Depends on gptchk_pkg (status codes, constants, CRC step, signature table).
//
// Channel   Dir  Handshake                   Contents
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: data_byte; tuser: req_type; tlast: last
// m_axis    out  m_axis_tvalid/m_axis_tready tuser: phase; tdata: status, lba, count, size
// cfg       in   cfg_we (no back-pressure)   cfg_wdata: sector_bytes
//
// One byte per cycle sustained. A request lands in the input register; from there
// the CRC step, field capture and verdict logic update the state and, on a last
// byte, load the result register. A non-last byte advances even when a result is
// stalled; only a last byte waits for the result register to drain. Reset
// (arst_n low) clears the checker state, sets sector_bytes to 512 and empties
// both registers.
module gpt_header_crc_checker_unit #(
	parameter int unsigned MAX_SECTOR_BYTES = gptchk_pkg::DEF_MAX_SECTOR_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: sector_bytes
	input  logic                             cfg_we,
	input  logic [gptchk_pkg::SECTOR_W-1:0]  cfg_wdata,
	// input requests
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
	input  logic                             s_axis_tuser,  // [0] req_type
	input  logic                             s_axis_tlast,  // [0] last
	// verdicts
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [2:0] status, [66:3] entry_array_lba, [98:67] entry_count,
	// [130:99] entry_size, [135:131] zero
	output logic [135:0]                     m_axis_tdata,
	output logic                             m_axis_tuser   // [0] phase
);
	import gptchk_pkg::*;

	// ---------------------------------------------------------------- config
	logic [SECTOR_W-1:0] sector_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= SECTOR_RESET;
		end else if (cfg_we) begin
			sector_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------- input stage
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;
	logic       valid_s2;

	// A last byte needs a free result slot; any other byte moves on.
	assign adv_s1        = valid_s1 && (!last_s1 || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// ------------------------------------------------------- checker state
	logic [31:0] crc_q, idx_q, rev_q, hlen_q, hcrc_q, count_q, esize_q, acrc_q;
	logic [63:0] own_lba_q, arr_lba_q;
	logic        sig_ok_q, hdr_good_q;

	logic [31:0] nx_crc, nx_idx, nx_rev, nx_hlen, nx_hcrc, nx_count, nx_esize, nx_acrc;
	logic [63:0] nx_own_lba, nx_arr_lba;
	logic        nx_sig_ok, nx_hdr_good;

	logic [31:0] total;     // count * size, wrapped to 32 bits
	logic [31:0] limit;
	logic [32:0] n_bytes;   // bytes seen including this one
	logic [31:0] crc_fin;
	logic [7:0]  crc_data;
	gpt_status_t verdict;

	assign total   = count_q * esize_q;
	assign n_bytes = {1'b0, idx_q} + 33'd1;
	assign limit   = (32'(sector_q) < 32'(MAX_SECTOR_BYTES)) ? 32'(sector_q)
	                                                       : 32'(MAX_SECTOR_BYTES);

	// Field capture and CRC step for the byte in the input register.
	always_comb begin
		nx_crc      = crc_q;
		nx_rev      = rev_q;
		nx_hlen     = hlen_q;
		nx_hcrc     = hcrc_q;
		nx_own_lba  = own_lba_q;
		nx_arr_lba  = arr_lba_q;
		nx_count    = count_q;
		nx_esize    = esize_q;
		nx_acrc     = acrc_q;
		nx_sig_ok   = sig_ok_q;
		nx_hdr_good = hdr_good_q;
		crc_data    = byte_s1;
		if (!req_s1) begin
			// Header start: drop everything captured from an earlier header.
			if (idx_q == 32'd0) begin
				nx_rev      = '0;
				nx_hlen     = '0;
				nx_hcrc     = '0;
				nx_own_lba  = '0;
				nx_arr_lba  = '0;
				nx_count    = '0;
				nx_esize    = '0;
				nx_acrc     = '0;
				nx_hdr_good = 1'b0;
				nx_sig_ok   = 1'b1;
			end
			if (idx_q < 32'd8) begin
				if (byte_s1 != sig_char(idx_q[2:0])) nx_sig_ok = 1'b0;
			end else if (idx_q < 32'd12) begin
				nx_rev[8*idx_q[1:0] +: 8] = byte_s1;
			end else if (idx_q < 32'd16) begin
				nx_hlen[8*idx_q[1:0] +: 8] = byte_s1;
			end else if (idx_q < 32'd20) begin
				nx_hcrc[8*idx_q[1:0] +: 8] = byte_s1;
			end else if (idx_q >= 32'd24 && idx_q < 32'd32) begin
				nx_own_lba[8*idx_q[2:0] +: 8] = byte_s1;
			end else if (idx_q >= 32'd72 && idx_q < 32'd80) begin
				nx_arr_lba[8*idx_q[2:0] +: 8] = byte_s1;
			end else if (idx_q >= 32'd80 && idx_q < 32'd84) begin
				nx_count[8*idx_q[1:0] +: 8] = byte_s1;
			end else if (idx_q >= 32'd84 && idx_q < 32'd88) begin
				nx_esize[8*idx_q[1:0] +: 8] = byte_s1;
			end else if (idx_q >= 32'd88 && idx_q < 32'd92) begin
				nx_acrc[8*idx_q[1:0] +: 8] = byte_s1;
			end
			// The stored header CRC bytes count as zero.
			if (idx_q >= 32'd16 && idx_q < 32'd20) crc_data = 8'd0;
			if (idx_q < 32'd16 || idx_q < nx_hlen) nx_crc = crc_byte(crc_q, crc_data);
		end else begin
			if (idx_q < total) nx_crc = crc_byte(crc_q, byte_s1);
		end
	end

	assign crc_fin = nx_crc ^ ALL_ONES;

	// Verdict on a last byte; header checks in order, first failure wins.
	always_comb begin
		verdict = ST_OK;
		if (!req_s1) begin
			priority if (!nx_sig_ok || n_bytes < 33'd8) begin
				verdict = ST_SIGNATURE;
			end else if (nx_rev != GPT_REVISION) begin
				verdict = ST_REVISION;
			end else if (nx_hlen < MIN_HDR_SIZE || nx_hlen > limit) begin
				verdict = ST_SIZE;
			end else if (nx_own_lba != 64'd1) begin
				verdict = ST_MY_LBA;
			end else if (n_bytes < {1'b0, nx_hlen} || crc_fin != nx_hcrc) begin
				verdict = ST_HDR_CRC;
			end else begin
				verdict = ST_OK;
			end
		end else begin
			priority if (!hdr_good_q) begin
				verdict = ST_NO_HDR;
			end else if (n_bytes < {1'b0, total} || crc_fin != acrc_q) begin
				verdict = ST_ENTRY_CRC;
			end else begin
				verdict = ST_OK;
			end
		end
	end

	assign nx_idx = (idx_q == ALL_ONES) ? idx_q : idx_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= ALL_ONES;
			idx_q      <= '0;
			sig_ok_q   <= 1'b1;
			rev_q      <= '0;
			hlen_q     <= '0;
			hcrc_q     <= '0;
			own_lba_q  <= '0;
			arr_lba_q  <= '0;
			count_q    <= '0;
			esize_q    <= '0;
			acrc_q     <= '0;
			hdr_good_q <= 1'b0;
		end else if (adv_s1) begin
			rev_q     <= nx_rev;
			hlen_q    <= nx_hlen;
			hcrc_q    <= nx_hcrc;
			own_lba_q <= nx_own_lba;
			arr_lba_q <= nx_arr_lba;
			count_q   <= nx_count;
			esize_q   <= nx_esize;
			acrc_q    <= nx_acrc;
			if (last_s1) begin
				// End of phase: rewind counter and CRC; a header sets header_good from its verdict, an entry array keeps it.
				crc_q      <= ALL_ONES;
				idx_q      <= '0;
				sig_ok_q   <= 1'b1;
				hdr_good_q <= req_s1 ? nx_hdr_good : (verdict == ST_OK);
			end else begin
				crc_q      <= nx_crc;
				idx_q      <= nx_idx;
				sig_ok_q   <= nx_sig_ok;
				hdr_good_q <= nx_hdr_good;
			end
		end
	end

	// ---------------------------------------------------------- result stage
	logic        phase_s2;
	gpt_status_t status_s2;
	logic [63:0] lba_s2;
	logic [31:0] count_s2, size_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			phase_s2  <= req_s1;
			status_s2 <= verdict;
			lba_s2    <= nx_arr_lba;
			count_s2  <= nx_count;
			size_s2   <= nx_esize;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = phase_s2;
	assign m_axis_tdata  = {5'd0, size_s2, count_s2, lba_s2, status_s2};

	// ------------------------------------------------------------ assertions
	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (idx_q == 32'd0 && crc_q == ALL_ONES && sig_ok_q))
		else $error("phase end did not rewind index and CRC");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> valid_s2)
		else $error("last byte advanced without a result");

	a_hdr_good: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1 && !req_s1) |=> (hdr_good_q == (status_s2 == ST_OK)))
		else $error("header_good disagrees with header verdict");

	a_no_hdr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 == ST_NO_HDR) |-> phase_s2)
		else $error("no-header status on a header verdict");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for gpt_header_crc_checker_unit: streams GPT header and
// entry-array bytes, predicts every verdict and compares it field by field.
// Depends on gptchk_pkg and the checker RTL.
module tb;
	import gptchk_pkg::*;

	localparam int unsigned MAXS        = DEF_MAX_SECTOR_BYTES;
	localparam int          SETTLE      = 12;         // cycles to let in-flight bytes retire
	localparam longint      LIMIT_NS    = 4_000_000;  // watchdog time limit

	typedef bit [7:0] octet_t;

	// one request on the input stream
	typedef struct packed {
		bit     req;
		octet_t data;
		bit     last;
	} byte_req_t;

	// one expected verdict
	typedef struct {
		bit          phase;
		gpt_status_t status;
		bit [63:0]   lba;
		bit [31:0]   cnt;
		bit [31:0]   esz;
	} verdict_t;

	typedef enum int {HF_NONE, HF_SIG, HF_REV, HF_CRC} hdr_fault_t;

	localparam octet_t SIG_TXT [8] = '{8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [12:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic         m_axis_tuser;

	gpt_header_crc_checker_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	byte_req_t byte_q[$];     // requests waiting for the driver
	verdict_t  verdict_q[$];  // verdicts predicted but not yet seen
	octet_t    none_q[$];     // empty payload

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int err_cnt         = 0;
	int result_no       = 0;
	int stim_bytes      = 0;
	int stim_lasts      = 0;

	// checker state as the bench sees it
	bit [12:0] sector_sz  = 13'd512;
	bit [31:0] run_crc    = '1;
	bit [31:0] byte_pos   = '0;
	bit        sig_match  = 1'b1;
	bit [31:0] rev_w      = '0;
	bit [31:0] hdr_size   = '0;
	bit [31:0] hdr_crc_w  = '0;
	bit [63:0] own_lba_w  = '0;
	bit [63:0] arr_lba_w  = '0;
	bit [31:0] ent_cnt_w  = '0;
	bit [31:0] ent_sz_w   = '0;
	bit [31:0] arr_crc_w  = '0;
	bit        hdr_valid  = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("** gpt_header_crc_checker_unit: FAILED **");
		$finish;
	end

	// Reflected CRC-32, one data bit at a time, LSB first.
	function automatic bit [31:0] crc32_feed(input bit [31:0] acc, input octet_t d);
		bit [31:0] c;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[k])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// Finished CRC over the first len bytes; optionally count bytes 16..19 as zero.
	function automatic bit [31:0] crc32_span(input octet_t data_q[$], input int unsigned len,
		input bit mask_field);
		bit [31:0] acc;
		acc = '1;
		for (int unsigned k = 0; k < len; k++)
			acc = crc32_feed(acc, (mask_field && k >= 16 && k < 20) ? 8'h00 : data_q[k]);
		return ~acc;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] result %0d: %s got %h want %h", $realtime, result_no, what, got, want);
		err_cnt++;
	endtask

	// Advance the bench copy of the checker by one accepted request and queue
	// the verdict that a last byte produces.
	task automatic judge_byte(input bit req, input octet_t b, input bit last);
		bit [31:0]   i;
		bit [32:0]   n;
		bit [31:0]   total;
		bit [31:0]   lim;
		gpt_status_t st;
		verdict_t    v;
		i = byte_pos;
		n = {1'b0, i} + 33'd1;
		total = ent_cnt_w * ent_sz_w;
		st = ST_OK;
		if (!req) begin
			// header start: forget everything captured so far
			if (i == 0) begin
				rev_w = '0;
				hdr_size = '0;
				hdr_crc_w = '0;
				own_lba_w = '0;
				arr_lba_w = '0;
				ent_cnt_w = '0;
				ent_sz_w = '0;
				arr_crc_w = '0;
				hdr_valid = 1'b0;
				sig_match = 1'b1;
			end
			if (i < 8) begin
				if (b != SIG_TXT[i[2:0]])
					sig_match = 1'b0;
			end else if (i < 12)
				rev_w[i[1:0]*8 +: 8] = b;
			else if (i < 16)
				hdr_size[i[1:0]*8 +: 8] = b;
			else if (i < 20)
				hdr_crc_w[i[1:0]*8 +: 8] = b;
			else if (i >= 24 && i < 32)
				own_lba_w[i[2:0]*8 +: 8] = b;
			else if (i >= 72 && i < 80)
				arr_lba_w[i[2:0]*8 +: 8] = b;
			else if (i >= 80 && i < 84)
				ent_cnt_w[i[1:0]*8 +: 8] = b;
			else if (i >= 84 && i < 88)
				ent_sz_w[i[1:0]*8 +: 8] = b;
			else if (i >= 88 && i < 92)
				arr_crc_w[i[1:0]*8 +: 8] = b;
			// the stored header crc field enters its own CRC as zeros
			if (i < 16 || i < hdr_size)
				run_crc = crc32_feed(run_crc, (i >= 16 && i < 20) ? 8'h00 : b);
		end else if (i < total) begin
			run_crc = crc32_feed(run_crc, b);
		end
		if (byte_pos != '1)
			byte_pos++;
		if (last) begin
			if (!req) begin
				lim = (32'(sector_sz) < MAXS) ? 32'(sector_sz) : MAXS;
				if (!sig_match || n < 8)
					st = ST_SIGNATURE;
				else if (rev_w != GPT_REVISION)
					st = ST_REVISION;
				else if (hdr_size < MIN_HDR_SIZE || hdr_size > lim)
					st = ST_SIZE;
				else if (own_lba_w != 64'd1)
					st = ST_MY_LBA;
				else if (n < {1'b0, hdr_size} || ~run_crc != hdr_crc_w)
					st = ST_HDR_CRC;
				hdr_valid = (st == ST_OK);
			end else begin
				if (!hdr_valid)
					st = ST_NO_HDR;
				else if (n < {1'b0, total} || ~run_crc != arr_crc_w)
					st = ST_ENTRY_CRC;
			end
			v.phase = req;
			v.status = st;
			v.lba = arr_lba_w;
			v.cnt = ent_cnt_w;
			v.esz = ent_sz_w;
			verdict_q = {verdict_q, v};
			byte_pos = '0;
			run_crc = '1;
			sig_match = 1'b1;
		end
	endtask

	// Driver: retire the accepted request into the prediction, then load the
	// next one when the slot is free and this cycle is not an idle one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				judge_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					byte_req_t r;
					r = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= r.req;
					s_axis_tdata  <= r.data;
					s_axis_tlast  <= r.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted verdict with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("verdict with none expected", m_axis_tdata[63:0], '0);
				end else begin
					verdict_t want;
					want = verdict_q.pop_front();
					if (m_axis_tuser !== want.phase)
						report_mismatch("phase", 64'(m_axis_tuser), 64'(want.phase));
					if (m_axis_tdata[2:0] !== want.status)
						report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
					if (m_axis_tdata[66:3] !== want.lba)
						report_mismatch("entry_array_lba", m_axis_tdata[66:3], want.lba);
					if (m_axis_tdata[98:67] !== want.cnt)
						report_mismatch("entry_count", 64'(m_axis_tdata[98:67]), 64'(want.cnt));
					if (m_axis_tdata[130:99] !== want.esz)
						report_mismatch("entry_size", 64'(m_axis_tdata[130:99]), 64'(want.esz));
					if (m_axis_tdata[135:131] !== 5'd0)
						report_mismatch("pad bits", 64'(m_axis_tdata[135:131]), '0);
				end
				result_no++;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Queue n requests of one phase; bytes past the payload are random.
	// flip_at marks one request that travels with the other req_type.
	task automatic send_stream(input bit req, input octet_t data_q[$], input int n,
		input int flip_at);
		byte_req_t r;
		for (int k = 0; k < n; k++) begin
			r.req  = (k == flip_at) ? ~req : req;
			r.data = (k < data_q.size()) ? data_q[k] : octet_t'($urandom_range(255));
			r.last = (k == n - 1);
			byte_q = {byte_q, r};
		end
		stim_bytes += n;
		stim_lasts++;
	endtask

	task automatic put_le(inout octet_t img[$], input int off, input bit [63:0] v, input int nb);
		for (int k = 0; k < nb; k++)
			img[off + k] = v[k*8 +: 8];
	endtask

	// Build a header image with the given fields and queue send_len bytes of it
	// (0 sends the whole image).
	task automatic send_header(input bit [31:0] hsize, input bit [63:0] own_lba,
		input bit [63:0] alba, input bit [31:0] cnt, input bit [31:0] esz,
		input bit [31:0] acrc, input hdr_fault_t fault, input int send_len);
		octet_t    img[$];
		int        len;
		int        n;
		bit [31:0] rev;
		bit [31:0] hcrc;
		len = (hsize >= 92 && hsize <= MAXS) ? int'(hsize) : 92;
		for (int k = 0; k < len; k++)
			img = {img, octet_t'($urandom_range(255))};
		for (int k = 0; k < 8; k++)
			img[k] = SIG_TXT[k];
		rev = GPT_REVISION;
		if (fault == HF_REV)
			rev ^= 32'h1 << $urandom_range(31);
		put_le(img, 8, 64'(rev), 4);
		put_le(img, 12, 64'(hsize), 4);
		put_le(img, 16, 64'd0, 4);
		put_le(img, 24, own_lba, 8);
		put_le(img, 72, alba, 8);
		put_le(img, 80, 64'(cnt), 4);
		put_le(img, 84, 64'(esz), 4);
		put_le(img, 88, 64'(acrc), 4);
		hcrc = crc32_span(img, (hsize < len) ? hsize : len, 1'b1);
		if (fault == HF_CRC)
			hcrc ^= 32'h1 << $urandom_range(31);
		put_le(img, 16, 64'(hcrc), 4);
		if (fault == HF_SIG)
			img[$urandom_range(7)] ^= 8'h1 << $urandom_range(7);
		n = (send_len > 0) ? send_len : len;
		send_stream(1'b0, img, n, -1);
	endtask

	// Hold until the driver is empty and every verdict has come, then let
	// any trailing non-last bytes retire.
	task automatic wait_idle();
		@(negedge clk);
		while (byte_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_sector(input bit [12:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sector_sz = v;
		repeat (2) @(posedge clk);
	endtask

	// One random transaction: mostly a well-formed header followed by entry
	// arrays, with one field or the stream length broken now and then.
	task automatic run_scenario();
		bit [31:0]  cnt;
		bit [31:0]  esz;
		bit [31:0]  total;
		bit [31:0]  hsize;
		bit [31:0]  lim;
		bit [31:0]  acrc;
		bit [63:0]  alba;
		bit [63:0]  own;
		octet_t     ent[$];
		octet_t     use_q[$];
		hdr_fault_t fault;
		int         pick;
		int         sh;
		int         hlen;
		int         n;
		int         flip;
		int         idx;
		byte_req_t  r;
		lim = (32'(sector_sz) < MAXS) ? 32'(sector_sz) : MAXS;
		pick = $urandom_range(99);
		if (pick < 6) begin
			// noise: random phases, random lasts, mixed kinds
			n = $urandom_range(1, 24);
			for (int k = 0; k < n; k++) begin
				r.req  = 1'($urandom_range(1));
				r.data = octet_t'($urandom_range(255));
				r.last = (k == n - 1) || ($urandom_range(9) == 0);
				byte_q = {byte_q, r};
				if (r.last)
					stim_lasts++;
			end
			stim_bytes += n;
			return;
		end
		// entry geometry: small, wrapping to small, or huge
		pick = $urandom_range(99);
		if (pick < 70) begin
			cnt = $urandom_range(0, 8);
			esz = $urandom_range(0, 24);
		end else if (pick < 85) begin
			sh  = $urandom_range(1, 6);
			esz = 32'h1 << sh;
			cnt = ($urandom << (32 - sh)) | $urandom_range(0, 3);
		end else begin
			cnt = $urandom;
			esz = $urandom;
		end
		total = cnt * esz;
		if (total <= 512) begin
			for (int k = 0; k < int'(total); k++)
				ent = {ent, octet_t'($urandom_range(255))};
			acrc = crc32_span(ent, total, 1'b0);
		end else begin
			acrc = $urandom;
		end
		alba  = {$urandom, $urandom};
		hsize = ($urandom_range(99) < 96) ? $urandom_range(92, 104) : $urandom_range(92, 256);
		own   = 64'd1;
		fault = HF_NONE;
		hlen  = 0;
		pick  = $urandom_range(99);
		if (pick >= 60) begin
			case (pick % 8)
				0: fault = HF_SIG;
				1: fault = HF_REV;
				2: hsize = $urandom_range(0, 91);
				3: begin
					if ($urandom_range(1))
						hsize = lim + 1 + $urandom_range(0, 63);
					else
						hsize = $urandom | 32'h8000_0000;
					// the size check needs only the first fields
					hlen = 40;
				end
				4: begin
					own = {$urandom, $urandom};
					if (own == 64'd1)
						own = 64'd0;
				end
				5: fault = HF_CRC;
				6: hlen = $urandom_range(1, hsize - 1);
				default: hlen = hsize + $urandom_range(1, 40);
			endcase
		end
		send_header(hsize, own, alba, cnt, esz, acrc, fault, hlen);
		// header_good persists, so several entry passes may follow one header
		repeat ($urandom_range(0, 2)) begin
			use_q = ent;
			n = (total <= 512) ? int'(total) : $urandom_range(1, 64);
			if (n == 0)
				n = $urandom_range(1, 4);
			flip = -1;
			pick = $urandom_range(99);
			if (pick >= 65 && pick < 75) begin
				if (n > 1)
					n = $urandom_range(1, n - 1);
			end else if (pick >= 75 && pick < 85) begin
				n += $urandom_range(1, 16);
			end else if (pick >= 85 && pick < 93) begin
				if (use_q.size() > 0) begin
					idx = $urandom_range(0, use_q.size() - 1);
					use_q[idx] ^= 8'h1 << $urandom_range(7);
				end
			end else if (pick >= 93) begin
				if (n > 1)
					flip = $urandom_range(0, n - 2);
			end
			send_stream(1'b1, use_q, n, flip);
		end
		// drain now and then so that the sender waits out every verdict
		if ($urandom_range(9) == 0)
			wait_idle();
	endtask

	initial begin
		octet_t    ent[$];
		bit [31:0] acrc;
		int        base_bytes;
		int        base_lasts;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed checks at the reset sector size, no idling
		send_stream(1'b1, none_q, 1, -1);                        // entry before any header
		send_stream(1'b0, none_q, 1, -1);                        // one-byte header
		send_header(92, 1, 0, 0, 0, 0, HF_NONE, 7);              // stops inside the signature
		send_header(92, 1, 64'd0, 0, 0, 32'd0, HF_NONE, 0);      // minimal good header
		send_stream(1'b1, none_q, 1, -1);                        // empty array
		ent = '{8'hFF};
		acrc = crc32_span(ent, 1, 1'b0);
		send_header(92, 1, '1, '1, '1, acrc, HF_NONE, 0);       // product wraps to one byte
		send_stream(1'b1, ent, 1, -1);
		ent = '{8'h00};
		send_stream(1'b1, ent, 1, -1);                           // wrong array crc
		send_header(92, 1, 64'd5, 1, 1, 0, HF_REV, 12);          // cut right after the revision
		send_stream(1'b1, none_q, 2, -1);                        // header no longer valid
		send_header(91, 1, 64'd2, 0, 0, 0, HF_NONE, 16);         // size below minimum
		send_header(512, 1, 64'd2, 0, 0, 32'd0, HF_NONE, 40);    // size at the sector limit, cut
		send_header(513, 1, 64'd2, 0, 0, 0, HF_NONE, 16);        // one past it
		send_header(92, '1, 64'd2, 0, 0, 0, HF_NONE, 32);        // my_lba wrong
		send_header(92, 1, 64'd2, 0, 0, 0, HF_SIG, 8);
		send_header(92, 1, 64'd2, 0, 0, 0, HF_CRC, 0);
		send_header(100, 1, 64'd2, 0, 0, 0, HF_NONE, 60);        // short header stream
		ent = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
		acrc = crc32_span(ent, 4, 1'b0);
		send_header(92, 1, 64'h8000_0000_0000_0001, 32'h4000_0001, 4, acrc, HF_NONE, 120);
		send_stream(1'b1, ent, 3, -1);                           // short entry stream
		send_stream(1'b1, ent, 4, -1);
		send_stream(1'b1, ent, 10, -1);                          // bytes past the array ignored

		write_sector(13'd4096);
		send_header(4096, 1, 64'd7, 0, 0, 32'd0, HF_NONE, 40);
		send_header(4097, 1, 64'd7, 0, 0, 0, HF_NONE, 16);
		write_sector(13'd8191);                                  // clamps to the parameter
		send_header(4097, 1, 64'd7, 0, 0, 0, HF_NONE, 16);
		send_header(4096, 1, 64'd7, 0, 0, 32'd0, HF_NONE, 40);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_sector(13'd512);
				1: write_sector(13'd4096);
				2: write_sector(13'($urandom_range(512, 4096)));
				default: write_sector(13'd8191);
			endcase
			sender_idle_pct = (ph == 1) ? 75 : (ph == 3) ? 11 : 0;
			recv_stall_pct  = (ph == 2) ? 75 : (ph == 3) ? 11 : 0;
			base_bytes = stim_bytes;
			base_lasts = stim_lasts;
			while (stim_bytes - base_bytes < 60 || stim_lasts - base_lasts < 2)
				run_scenario();
		end

		wait_idle();
		if (err_cnt == 0)
			$display("** gpt_header_crc_checker_unit: PASSED **");
		else
			$display("** gpt_header_crc_checker_unit: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/gptchk_pkg.sv
hw/rtl/gpt_header_crc_checker_unit.sv
tb/tb.sv
